/* rtl/rpst_pkg.sv */
// ----------------------------------------------------------------------------
// rpst_pkg: shared types and constants for the reflection plane slot table
// Beat formats, outcome codes and the scan token handed along the cell chain.
// ----------------------------------------------------------------------------
package rpst_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    OUT_HIT_SAME    = 3'd0,
    OUT_HIT_REFRESH = 3'd1,
    OUT_FREE_TAKEN  = 3'd2,
    OUT_EVICTED     = 3'd3,
    OUT_DROPPED     = 3'd4,
    OUT_FLUSHED     = 3'd5
  } outcome_t;

  typedef struct packed {
    logic        command;
    logic [15:0] plane_height;
    logic [31:0] current_time;
  } request_t;

  typedef struct packed {
    logic [3:0] slot;
    outcome_t   outcome;
  } result_t;

  // Scan state carried from cell to cell
  typedef struct packed {
    logic                  valid;
    logic [15:0]           height;
    logic [31:0]           now;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic [31:0]           hit_time;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  lru_found;
    logic [SLOT_IDX_W-1:0] lru_idx;
    logic [31:0]           lru_time;
  } token_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic                  en;
    logic                  flush;
    logic [SLOT_IDX_W-1:0] idx;
    logic [15:0]           height;
    logic [31:0]           now;
  } slot_wr_t;

endpackage

/* rtl/rpst_cell.sv */
// ----------------------------------------------------------------------------
// rpst_cell: one plane slot of the table
// Holds valid, height and last-used time; folds its slot into the passing
// scan token and takes broadcast updates addressed to it.
// ----------------------------------------------------------------------------
module rpst_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rpst_pkg::SLOT_IDX_W-1:0] idx,
  input  rpst_pkg::token_t               tok_in,
  input  rpst_pkg::slot_wr_t             wr,
  output rpst_pkg::token_t               tok_out
);
  import rpst_pkg::*;

  logic        valid;
  logic [15:0] height;
  logic [31:0] last_used;
  token_t      tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.hit) begin
      if (!valid) begin
        if (!tok_in.free_found) begin
          tok_next.free_found = 1'b1;
          tok_next.free_idx   = idx;
        end
      end else if (height == tok_in.height) begin
        tok_next.hit      = 1'b1;
        tok_next.hit_idx  = idx;
        tok_next.hit_time = last_used;
      end else if (!tok_in.lru_found || (last_used < tok_in.lru_time)) begin
        tok_next.lru_found = 1'b1;
        tok_next.lru_idx   = idx;
        tok_next.lru_time  = last_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.flush) begin
      valid <= 1'b0;
    end else if (wr.en && (wr.idx == idx)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!wr.flush && wr.en && (wr.idx == idx)) begin
      height    <= wr.height;
      last_used <= wr.now;
    end
  end

endmodule

/* rtl/reflection_plane_slot_table.sv */
// ----------------------------------------------------------------------------
// reflection_plane_slot_table: LRU table of reflection plane slots
// Registers plane heights into a fixed set of slots, replacing the least
// recently used slot when the table is full, unless that slot was already used this frame.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a rising edge with start high and busy low.
//   request.command selects an add (look up plane_height, stamp it with
//   current_time) or a flush (free every slot).
//   Each request gives exactly one result beat: done is high for one cycle
//   while result carries the slot and the outcome code. The receiver cannot
//   stall; the beat is gone after that cycle.
//   Sequencing: an add walks a scan token down a chain of SLOTS cells, one
//   cell per cycle, then decides on the finished scan and raises done while
//   moving to ST_WRITE, where the chosen slot is written. A flush skips the
//   chain: done and the flush update are registered at the accept edge, and
//   the table passes through ST_WRITE back to idle. busy stays high until
//   then, so a new request is taken only once the previous one is through.
//   The cell chain length sets the add rate.
//   Reset: synchronous and active high; clears every valid bit so all slots
//   are free, drops any scan in flight and returns to idle.
// ----------------------------------------------------------------------------
module reflection_plane_slot_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rpst_pkg::request_t request,
  output logic               done,
  output rpst_pkg::result_t  result
);
  import rpst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t   state;
  state_t   state_next;
  logic     done_next;
  token_t   tok [SLOTS+1];
  token_t   seed;
  token_t   seed_next;
  slot_wr_t wr;
  slot_wr_t wr_next;
  slot_wr_t scan_wr;
  result_t  result_next;
  result_t  scan_result;
  token_t   last;
  logic     accept;
  logic [SLOTS-1:0] tok_live;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign last   = tok[SLOTS];
  assign tok[0] = seed;

  // Cell chain: cell g reads tok[g] and hands its token to tok[g+1]
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rpst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (SLOT_IDX_W'(g)),
      .tok_in  (tok[g]),
      .wr      (wr),
      .tok_out (tok[g+1])
    );
    assign tok_live[g] = tok[g].valid;
  end

  // Decide on the finished scan: hit, free slot, eviction or drop
  always_comb begin
    scan_wr        = '0;
    scan_wr.height = last.height;
    scan_wr.now    = last.now;
    scan_result    = '0;
    if (last.hit) begin
      scan_result.slot = 4'(last.hit_idx);
      if (last.hit_time == last.now) begin
        scan_result.outcome = OUT_HIT_SAME;
      end else begin
        scan_result.outcome = OUT_HIT_REFRESH;
        scan_wr.en          = 1'b1;
        scan_wr.idx         = last.hit_idx;
      end
    end else if (last.free_found) begin
      scan_result.slot    = 4'(last.free_idx);
      scan_result.outcome = OUT_FREE_TAKEN;
      scan_wr.en          = 1'b1;
      scan_wr.idx         = last.free_idx;
    end else if (!last.lru_found || (last.lru_time == last.now)) begin
      // Victim already used this frame: drop the request
      scan_result.outcome = OUT_DROPPED;
    end else begin
      scan_result.slot    = 4'(last.lru_idx);
      scan_result.outcome = OUT_EVICTED;
      scan_wr.en          = 1'b1;
      scan_wr.idx         = last.lru_idx;
    end
  end

  // Control: seed a scan on an add, report a flush at once, hold the
  // result until the next beat and pulse the slot update for one cycle
  always_comb begin
    state_next      = state;
    done_next       = 1'b0;
    wr_next         = '0;
    result_next     = result;
    seed_next       = seed;
    seed_next.valid = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (request.command == CMD_FLUSH) begin
            // Flush needs no scan: clear valid bits and report at once
            wr_next.flush       = 1'b1;
            done_next           = 1'b1;
            result_next.slot    = '0;
            result_next.outcome = OUT_FLUSHED;
            state_next          = ST_WRITE;
          end else begin
            seed_next        = '0;
            seed_next.valid  = 1'b1;
            seed_next.height = request.plane_height;
            seed_next.now    = request.current_time;
            state_next       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last.valid) begin
          wr_next     = scan_wr;
          result_next = scan_result;
          done_next   = 1'b1;
          state_next  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      wr     <= '0;
      seed   <= '0;
      result <= '0;
    end else begin
      state  <= state_next;
      done   <= done_next;
      wr     <= wr_next;
      seed   <= seed_next;
      result <= result_next;
    end
  end

  // Only one scan token travels the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_live))
    else $error("more than one scan token in the cell chain");

  // A result beat is only ever given while the table is busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat while idle");

  // Each accepted request blocks further requests on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accept");

  // The result strobe lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // A slot update never coincides with a scan in flight
  a_wr_quiet: assert property (@(posedge clk) disable iff (rst)
    (wr.en || wr.flush) |-> (tok_live == '0) && !last.valid)
    else $error("slot update while a scan is in flight");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: reflection plane slot table
// Drives add and flush requests into the table. A shadow copy of the slots
// predicts each result beat, and every beat is checked against the oldest
// prediction still waiting. Directed cases cover filling the table, drops,
// hits, ties and flushes. Random frames of requests with idle bursts follow,
// and a final stretch runs with no idling.
// ----------------------------------------------------------------------------
module testbench;
  import rpst_pkg::*;

  // Worst case: an add runs the whole cell chain and may be followed by an idle burst.
  // This limit sits far above what ~1050 requests need.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int POOL_SIZE    = 24;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  reflection_plane_slot_table uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the slot table, updated at the edge that accepts a request
  logic        shadow_valid  [SLOTS];
  logic [15:0] shadow_height [SLOTS];
  logic [31:0] shadow_stamp  [SLOTS];

  // Result beats predicted but not yet seen on the outputs
  result_t     pending_results [$];
  result_t     oldest_result;

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  bit          idle_enable    = 1'b1;

  // Heights reused across frames so that hits and evictions actually occur
  logic [15:0] height_pool [POOL_SIZE];
  logic [31:0] frame_time;

  // --------------------------------------------------------------------------
  // Predict the result of one accepted request and apply it to the shadow
  // table. Scan slots in index order: a valid slot with the same height is a
  // hit; otherwise take the first free slot, or else evict the least recently
  // used one (lowest index on ties) unless it was used this very frame.
  // --------------------------------------------------------------------------
  function automatic result_t plane_table_predict(request_t req);
    result_t r;
    int      free_idx;
    int      lru_idx;
    int      i;
    free_idx = -1;
    lru_idx  = -1;
    r.slot    = '0;
    r.outcome = OUT_DROPPED;

    if (req.command == CMD_FLUSH) begin
      // Clear valid bits only; heights and stamps stay behind
      for (i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
      r.outcome = OUT_FLUSHED;
      return r;
    end

    for (i = 0; i < SLOTS; i++) begin
      if (!shadow_valid[i]) begin
        if (free_idx < 0) free_idx = i;
      end else if (shadow_height[i] == req.plane_height) begin
        r.slot = 4'(i);
        if (shadow_stamp[i] == req.current_time) begin
          r.outcome = OUT_HIT_SAME;
        end else begin
          shadow_stamp[i] = req.current_time;
          r.outcome = OUT_HIT_REFRESH;
        end
        return r;
      end else if (lru_idx < 0 || shadow_stamp[i] < shadow_stamp[lru_idx]) begin
        lru_idx = i;
      end
    end

    if (free_idx >= 0) begin
      shadow_valid[free_idx]  = 1'b1;
      shadow_height[free_idx] = req.plane_height;
      shadow_stamp[free_idx]  = req.current_time;
      r.slot    = 4'(free_idx);
      r.outcome = OUT_FREE_TAKEN;
      return r;
    end

    // Victim touched this frame: drop the request, leave the table alone
    if (lru_idx < 0 || shadow_stamp[lru_idx] == req.current_time) return r;

    shadow_height[lru_idx] = req.plane_height;
    shadow_stamp[lru_idx]  = req.current_time;
    r.slot    = 4'(lru_idx);
    r.outcome = OUT_EVICTED;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: sample at the rising edge; a beat lives for one cycle
  // only, so compare it the moment done is seen.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat slot %0d outcome %0d with nothing expected",
                                  result.slot, result.outcome));
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.slot !== oldest_result.slot)
          report_mismatch($sformatf("slot got %0d expected %0d",
                                    result.slot, oldest_result.slot));
        if (result.outcome !== oldest_result.outcome)
          report_mismatch($sformatf("outcome got %0d expected %0d",
                                    result.outcome, oldest_result.outcome));
      end
    end
  end

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Drop start and keep it low for the gap length n; drive at the falling edge
  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Send one request beat: raise start at the falling edge, hold until a
  // rising edge sees busy low, then record the prediction. Start stays high
  // into the next beat unless an idle burst follows.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic cmd, input logic [15:0] height,
                              input logic [31:0] stamp);
    request_t req;
    req.command      = cmd;
    req.plane_height = height;
    req.current_time = stamp;
    @(negedge clk);
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(plane_table_predict(req));
    if (idle_enable && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
  endtask

  task automatic add_plane(input logic [15:0] height, input logic [31:0] stamp);
    send_request(CMD_ADD, height, stamp);
  endtask

  task automatic flush_all();
    send_request(CMD_FLUSH, 16'($urandom), $urandom);
  endtask

  // Fill every slot in one frame: heights at both extremes plus a spread
  task automatic test_fill_free_slots();
    int i;
    add_plane(16'h0000, 32'd0);
    add_plane(16'hffff, 32'd0);
    for (i = 2; i < SLOTS; i++) add_plane(16'(16'h1000 + i * 16'h0111), 32'd0);
  endtask

  // Full table, every slot stamped this frame: a miss drops, a hit holds
  task automatic test_same_frame();
    add_plane(16'h1234, 32'd0);
    add_plane(16'hffff, 32'd0);
  endtask

  // Refresh a hit, evict on a tie (lowest index wins), then evict with a time
  // of 5, later than the victim's stamp of zero, which counts as another frame
  task automatic test_refresh_and_evict();
    add_plane(16'hffff, 32'hffff_ffff);
    add_plane(16'habcd, 32'hffff_ffff);
    add_plane(16'h5555, 32'd5);
  endtask

  // Flush frees slots but keeps heights: the same height must miss afterwards
  task automatic test_flush();
    flush_all();
    add_plane(16'habcd, 32'd7);
    add_plane(16'h5555, 32'd7);
  endtask

  // --------------------------------------------------------------------------
  // Random frames. Most requests use the current frame time and a height from
  // a small pool; some use odd times or raw heights, a few flush. Some frames
  // walk the whole pool in one frame to fill the table and force drops.
  // --------------------------------------------------------------------------
  task automatic test_random_frames(input int n_items);
    int          sent;
    int          burst;
    int          pick;
    int          i;
    logic [15:0] height;
    logic [31:0] stamp;
    sent = 0;
    while (sent < n_items) begin
      // advance the frame, now and then jump far
      if ($urandom_range(0, 19) == 0) frame_time = $urandom;
      else frame_time = frame_time + $urandom_range(1, 50);
      if ($urandom_range(0, 7) == 0)
        for (i = 0; i < 4; i++) height_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);

      if ($urandom_range(0, 5) == 0) begin
        // walk the pool in one frame
        for (i = 0; i < POOL_SIZE; i++) add_plane(height_pool[i], frame_time);
        sent += POOL_SIZE;
      end else begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            flush_all();
          end else begin
            if (pick < 12) height = 16'($urandom);
            else height = height_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 80) stamp = frame_time;
            else if (pick < 88) stamp = frame_time - $urandom_range(1, 30);
            else if (pick < 95) stamp = $urandom;
            else stamp = frame_time + $urandom_range(1, 5);
            add_plane(height, stamp);
          end
        end
        sent += burst;
      end
    end
  endtask

  // Back-to-back requests with start never dropped
  task automatic test_back_to_back(input int n_items);
    idle_enable = 1'b0;
    test_random_frames(n_items);
  endtask

  initial begin : run
    int i;
    for (i = 0; i < SLOTS; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_height[i] = '0;
      shadow_stamp[i]  = '0;
    end
    for (i = 0; i < POOL_SIZE; i++) height_pool[i] = 16'($urandom);
    frame_time = $urandom_range(1000, 100000);

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_free_slots();
    test_same_frame();
    test_refresh_and_evict();
    test_flush();
    test_random_frames(900);
    test_back_to_back(130);

    // Drop start, wait for every predicted beat, then let the pipe drain
    idle_gap(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rpst_pkg.sv
rtl/rpst_cell.sv
rtl/reflection_plane_slot_table.sv
tb/testbench.sv
